/* rtl/core/mi64_pkg.sv */
// ----------------------------------------------------------------------------
// mi64_pkg
// Shared constants for the 64-bit modular inverse core and its checker.
// ----------------------------------------------------------------------------
package mi64_pkg;

  // Register file layout: one 64-bit register, so registers sit at 8*i.
  localparam int unsigned ADDR_BITS  = 4;
  localparam int unsigned DATA_BITS  = 64;
  localparam logic        REG_MODULUS = 1'b0;

  // Modulus after reset: 2^64 - 59.
  localparam logic [63:0] MOD_RESET_64 = 64'hFFFF_FFFF_FFFF_FFC5;

endpackage

/* rtl/core/modular_inverse_64_core.sv */
// ----------------------------------------------------------------------------
// modular_inverse_64_core
// Modular inverse by the unsigned extended Euclidean algorithm.
// ----------------------------------------------------------------------------
// Each item takes one value and returns its inverse modulo the modulus
// register, or no_inverse with inverse 0 when the gcd is not 1. The work runs
// one Euclid step at a time on a shared bit-serial divider that produces
// quotient times cofactor along with the remainder. Each step tests the
// remainder and, while it is not zero, runs the divider, for up to about 93
// steps for 64-bit words.
// One item is in flight at a time: in_ready is low from acceptance until the
// result item has been taken. The modulus is written over the APB port at
// address 0; the user must write it only while the block is idle, as the
// block itself does not enforce this.
module modular_inverse_64_core import mi64_pkg::*; #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [WORD_BITS-1:0] value,
  // Result items
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WORD_BITS-1:0] inverse,
  output logic                 no_inverse,
  // Configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  localparam logic [WORD_BITS-1:0] MOD_RESET = MOD_RESET_64[WORD_BITS-1:0];
  localparam logic [WORD_BITS-1:0] ONE       = WORD_BITS'(1);

  logic [1:0]           state;
  logic [WORD_BITS-1:0] modulus;
  logic [WORD_BITS-1:0] a_rem;
  logic [WORD_BITS-1:0] b_rem;
  logic [WORD_BITS-1:0] a_co;
  logic [WORD_BITS-1:0] b_co;
  logic                 odd;
  logic                 div_start;
  logic                 div_done;
  logic [WORD_BITS-1:0] div_rem;
  logic [WORD_BITS-1:0] div_prod;
  logic                 reg_sel;

  // Configuration register access.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[3] == REG_MODULUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      modulus <= pwdata[WORD_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata[WORD_BITS-1:0] = modulus;
    end
  end

  // Handshake outputs follow the sequencer state.
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign div_start = (state == S_CHECK) && (b_rem != '0);

  mi64_div_unit #(.WORD_BITS(WORD_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (a_rem),
    .divisor   (b_rem),
    .mul_in    (b_co),
    .done      (div_done),
    .remainder (div_rem),
    .product   (div_prod)
  );

  // Sequencer: test remainder, run a division step, repeat until zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= (b_rem == '0) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_CHECK;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Euclid pairs, parity and the result.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      a_rem <= value;
      b_rem <= modulus;
      a_co  <= ONE;
      b_co  <= '0;
      odd   <= 1'b0;
    end else if (state == S_DIV && div_done) begin
      a_co  <= b_co;
      b_co  <= a_co + div_prod;
      a_rem <= b_rem;
      b_rem <= div_rem;
      odd   <= ~odd;
    end
    if (state == S_CHECK && b_rem == '0) begin
      no_inverse <= (a_rem != ONE);
      if (a_rem != ONE) begin
        inverse <= '0;
      end else begin
        inverse <= odd ? (modulus - a_co) : a_co;
      end
    end
  end

endmodule

/* rtl/core/mi64_div_unit.sv */
// ----------------------------------------------------------------------------
// mi64_div_unit
// Bit-serial restoring divider that also forms quotient times a multiplicand.
// ----------------------------------------------------------------------------
module mi64_div_unit import mi64_pkg::*; #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] divisor,
  input  logic [WORD_BITS-1:0] mul_in,
  output logic                 done,
  output logic [WORD_BITS-1:0] remainder,
  output logic [WORD_BITS-1:0] product
);

  localparam int unsigned CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

  logic                 run;
  logic [CNT_BITS-1:0]  cnt;
  logic [WORD_BITS-1:0] dq;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;
  logic                 qbit;
  logic [WORD_BITS-1:0] rem_next;
  logic [WORD_BITS-1:0] acc_next;

  // One quotient bit per cycle, most significant first. The product is
  // accumulated Horner-style from the same quotient bits, modulo 2^WORD_BITS.
  always_comb begin
    trial    = {remainder, dq[WORD_BITS-1]};
    diff     = trial - {1'b0, divisor};
    qbit     = ~diff[WORD_BITS];
    rem_next = qbit ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
    acc_next = {product[WORD_BITS-2:0], 1'b0} + (qbit ? mul_in : '0);
  end

  // Control: step through the dividend bits, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      product   <= '0;
      dq        <= dividend;
    end else if (run) begin
      remainder <= rem_next;
      product   <= acc_next;
      dq        <= {dq[WORD_BITS-2:0], 1'b0};
    end
  end

endmodule

/* rtl/core/mi64_checker.sv */
// ----------------------------------------------------------------------------
// mi64_checker
// Port-level checks for the modular inverse core, bound to the core module.
// ----------------------------------------------------------------------------
module mi64_checker import mi64_pkg::*; #(
  parameter int unsigned WORD_BITS = 64
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [WORD_BITS-1:0] inverse,
  input logic                 no_inverse
);

  // A stalled result item holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(inverse) && $stable(no_inverse))
    else $error("result item changed while stalled");

  // A failed inversion always reports zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_inverse |-> inverse == '0)
    else $error("no_inverse with nonzero inverse");

  // After an item is accepted the block is busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready right after accepting an item");

  // No new item is taken while a result waits.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

endmodule

bind modular_inverse_64_core mi64_checker #(.WORD_BITS(WORD_BITS)) u_mi64_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .inverse    (inverse),
  .no_inverse (no_inverse)
);
